### rtl/lpkp_pkg.sv
`timescale 1ns / 1ps

package lpkp_pkg;

  localparam int POWER_CODE_W = 3;
  localparam int BRAKE_CODE_W = 4;
  localparam int POWER_POS_W  = 4;
  localparam int BRAKE_POS_W  = 5;
  localparam int FLAG_W       = 7;
  localparam int OUT_DATA_W   = 16;

  localparam logic [POWER_CODE_W-1:0] POWER_CODE_NONE = 3'd0;
  localparam logic [POWER_CODE_W-1:0] POWER_CODE_OPEN = 3'd7;
  localparam logic [BRAKE_CODE_W-1:0] BRAKE_CODE_NONE = 4'd0;
  localparam logic [BRAKE_CODE_W-1:0] BRAKE_CODE_EMRG = 4'd10;

  localparam logic signed [POWER_POS_W-1:0] POWER_POS_INVALID = -4'sd1;
  localparam logic signed [POWER_POS_W-1:0] POWER_POS_OFF     = 4'sd0;
  localparam logic signed [POWER_POS_W-1:0] POWER_POS_MAX     = 4'sd5;
  localparam logic signed [BRAKE_POS_W-1:0] BRAKE_POS_INVALID = -5'sd1;
  localparam logic signed [BRAKE_POS_W-1:0] BRAKE_POS_RELEASE = 5'sd0;
  localparam logic signed [BRAKE_POS_W-1:0] BRAKE_POS_EMRG    = 5'sd9;

  // key flag bit positions
  localparam int KEY_POWER_FREE = 0;
  localparam int KEY_POWER_UP   = 1;
  localparam int KEY_POWER_DOWN = 2;
  localparam int KEY_BRAKE_FREE = 3;
  localparam int KEY_BRAKE_UP   = 4;
  localparam int KEY_BRAKE_DOWN = 5;
  localparam int KEY_BRAKE_EMRG = 6;

  // make is passed through within the same transaction, so only idle and break are held
  typedef enum logic [1:0] {
    PHASE_IDLE  = 2'b01,
    PHASE_BREAK = 2'b10
  } phase_t;

endpackage

### rtl/lever_position_key_pulser.sv
`timescale 1ns / 1ps

// channel  dir  tdata bits (lsb up)
// s_axis   in   [31:0] pin_sample
// m_axis   out  [0] power_free, [1] power_up, [2] power_down, [3] brake_free,
//               [4] brake_up, [5] brake_down, [6] brake_emergency,
//               [10:7] power_position, [15:11] brake_position
//
// one sample per cycle while the output is not stalled; the result shows in the cycle after acceptance, held
// in the output register until taken
// s_tready is low only while a result waits and m_tready is low
// rst (synchronous) sets both stored positions to -1, phases to idle and
// empties the output register

module lever_position_key_pulser #(
  parameter int POWER_PIN_BASE = 8,
  parameter int BRAKE_PIN_BASE = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [31:0]                      s_tdata,   // [31:0] pin_sample
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [lpkp_pkg::OUT_DATA_W-1:0]  m_tdata    // flags [6:0], power [10:7], brake [15:11]
);
  import lpkp_pkg::*;

  logic signed [POWER_POS_W-1:0] power_stored, power_stored_next;
  logic signed [BRAKE_POS_W-1:0] brake_stored, brake_stored_next;
  phase_t                        power_phase, power_phase_next;
  phase_t                        brake_phase, brake_phase_next;
  logic [FLAG_W-1:0]             flags_next;
  logic [OUT_DATA_W-1:0]         out_data;
  logic                          out_valid;

  logic [POWER_CODE_W-1:0]       power_code;
  logic [BRAKE_CODE_W-1:0]       brake_code;
  logic signed [POWER_POS_W-1:0] power_pos;
  logic signed [BRAKE_POS_W-1:0] brake_pos;
  logic                          power_ok, brake_ok;
  logic                          power_hit, brake_hit;
  logic                          in_xfer;

  assign s_tready = !out_valid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  assign power_code = s_tdata[POWER_PIN_BASE +: POWER_CODE_W];
  assign brake_code = s_tdata[BRAKE_PIN_BASE +: BRAKE_CODE_W];

  always_comb begin
    power_ok  = (power_code != POWER_CODE_NONE) && (power_code != POWER_CODE_OPEN);
    power_pos = $signed({1'b0, power_code} - 4'd1);
    brake_ok  = (brake_code != BRAKE_CODE_NONE);
    brake_pos = (brake_code >= BRAKE_CODE_EMRG) ? BRAKE_POS_EMRG
                                                : $signed({1'b0, brake_code} - 5'd1);

    power_hit = power_ok && (power_pos != power_stored) && (power_phase == PHASE_IDLE);
    brake_hit = brake_ok && (brake_pos != brake_stored) && (brake_phase == PHASE_IDLE);

    // a lever's flags are only nonzero in the transaction that detects a move
    flags_next = '0;
    if (power_hit) begin
      priority if (power_pos == POWER_POS_OFF) flags_next[KEY_POWER_FREE] = 1'b1;
      else if (power_stored > power_pos)       flags_next[KEY_POWER_DOWN] = 1'b1;
      else                                     flags_next[KEY_POWER_UP]   = 1'b1;
    end
    if (brake_hit) begin
      priority if (brake_pos == BRAKE_POS_RELEASE) flags_next[KEY_BRAKE_FREE] = 1'b1;
      else if (brake_pos == BRAKE_POS_EMRG)        flags_next[KEY_BRAKE_EMRG] = 1'b1;
      else if (brake_stored > brake_pos)           flags_next[KEY_BRAKE_DOWN] = 1'b1;
      else                                         flags_next[KEY_BRAKE_UP]   = 1'b1;
    end

    power_stored_next = power_hit ? power_pos : power_stored;
    brake_stored_next = brake_hit ? brake_pos : brake_stored;
    power_phase_next  = power_hit ? PHASE_BREAK : PHASE_IDLE;
    brake_phase_next  = brake_hit ? PHASE_BREAK : PHASE_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_stored <= POWER_POS_INVALID;
      brake_stored <= BRAKE_POS_INVALID;
      power_phase  <= PHASE_IDLE;
      brake_phase  <= PHASE_IDLE;
      out_valid    <= 1'b0;
    end else begin
      if (in_xfer) begin
        power_stored <= power_stored_next;
        brake_stored <= brake_stored_next;
        power_phase  <= power_phase_next;
        brake_phase  <= brake_phase_next;
        out_valid    <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data <= {brake_stored_next, power_stored_next, flags_next};
    end
  end

endmodule

### rtl/lpkp_checker.sv
`timescale 1ns / 1ps

module lpkp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [lpkp_pkg::OUT_DATA_W-1:0] m_tdata
);
  import lpkp_pkg::*;

  logic [POWER_POS_W-1:0] power_field;
  logic [BRAKE_POS_W-1:0] brake_field;

  assign power_field = m_tdata[10:7];
  assign brake_field = m_tdata[15:11];

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_power_one_key: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tdata[2:0]))
    else $error("more than one power key raised");

  a_brake_one_key: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tdata[6:3]))
    else $error("more than one brake key raised");

  a_power_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (power_field <= POWER_POS_MAX || power_field == POWER_POS_INVALID))
    else $error("power position out of range");

  a_brake_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (brake_field <= BRAKE_POS_EMRG || brake_field == BRAKE_POS_INVALID))
    else $error("brake position out of range");

endmodule

bind lever_position_key_pulser lpkp_checker u_lpkp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### tb/lever_position_key_pulser_tb.sv
`timescale 1ns / 1ps

module lever_position_key_pulser_tb;
  import lpkp_pkg::*;

  localparam int POWER_PIN_BASE = 8;
  localparam int BRAKE_PIN_BASE = 12;
  localparam int RESET_CYCLES   = 6;
  localparam int STALL_LIMIT    = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_PER_PHASE = 238;
  localparam int NUM_DIRECTED   = 25;

  typedef struct packed {
    logic [31:0]           pins;
    logic                  typed;
    logic [OUT_DATA_W-1:0] want;
  } pin_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // predictor state
  logic signed [POWER_POS_W-1:0] power_notch;
  logic signed [BRAKE_POS_W-1:0] brake_step;
  phase_t                        power_ph;
  phase_t                        brake_ph;
  logic [FLAG_W-1:0]             keys;

  pin_row_t              sent_rows[$];
  logic [OUT_DATA_W-1:0] key_words_due[$];
  int                    errors = 0;
  int                    idle_cycles = 0;
  int                    src_idle_pct = 0;
  int                    sink_stall_pct = 0;

  // first rows are typed in: all invalid after reset, then all ones (power open, brake emergency)
  pin_row_t directed_rows[NUM_DIRECTED] = '{
    '{32'h0000_0000, 1'b1, 16'hFF80},
    '{32'hFFFF_FFFF, 1'b1, 16'h4FC0},
    '{32'h0000_0100, 1'b0, 16'h0000},
    '{32'h0000_0600, 1'b0, 16'h0000},
    '{32'h0000_0600, 1'b0, 16'h0000},
    '{32'h0000_0300, 1'b0, 16'h0000},
    '{32'h0000_0400, 1'b0, 16'h0000},
    '{32'h0000_0400, 1'b0, 16'h0000},
    '{32'h0000_1000, 1'b0, 16'h0000},
    '{32'h0000_9000, 1'b0, 16'h0000},
    '{32'h0000_9000, 1'b0, 16'h0000},
    '{32'h0000_2000, 1'b0, 16'h0000},
    '{32'h0000_A000, 1'b0, 16'h0000},
    '{32'h0000_A000, 1'b0, 16'h0000},
    '{32'h0000_5000, 1'b0, 16'h0000},
    '{32'hFFFF_08FF, 1'b0, 16'h0000},
    '{32'h0000_0700, 1'b0, 16'h0000},
    '{32'hFFFF_F2FF, 1'b0, 16'h0000},
    '{32'h0000_0000, 1'b0, 16'h0000},
    '{32'h0000_0500, 1'b0, 16'h0000},
    '{32'h0000_B300, 1'b0, 16'h0000},
    '{32'h0000_C000, 1'b0, 16'h0000},
    '{32'h0000_D200, 1'b0, 16'h0000},
    '{32'h0000_E100, 1'b0, 16'h0000},
    '{32'h0000_F600, 1'b0, 16'h0000}
  };

  lever_position_key_pulser #(
    .POWER_PIN_BASE(POWER_PIN_BASE),
    .BRAKE_PIN_BASE(BRAKE_PIN_BASE)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #6 clk = ~clk;

  function automatic logic [OUT_DATA_W-1:0] predict_keys(input logic [31:0] pins);
    logic [POWER_CODE_W-1:0]       pc;
    logic [BRAKE_CODE_W-1:0]       bc;
    logic signed [POWER_POS_W-1:0] p;
    logic signed [BRAKE_POS_W-1:0] b;
    logic                          p_ok;
    logic                          b_ok;
    pc = pins[POWER_PIN_BASE +: POWER_CODE_W];
    bc = pins[BRAKE_PIN_BASE +: BRAKE_CODE_W];
    p_ok = (pc != POWER_CODE_NONE) && (pc != POWER_CODE_OPEN);
    p = $signed({1'b0, pc}) - 4'sd1;
    b_ok = (bc != BRAKE_CODE_NONE);
    if (bc >= BRAKE_CODE_EMRG) begin
      b = BRAKE_POS_EMRG;
    end else begin
      b = $signed({1'b0, bc}) - 5'sd1;
    end

    // make is left at once, so a detected move ends the step in break
    if (p_ok && p != power_notch && power_ph == PHASE_IDLE) begin
      if (p == POWER_POS_OFF) begin
        keys[KEY_POWER_FREE] = 1'b1;
      end else if (power_notch > p) begin
        keys[KEY_POWER_DOWN] = 1'b1;
      end else begin
        keys[KEY_POWER_UP] = 1'b1;
      end
      power_notch = p;
      power_ph = PHASE_BREAK;
    end else if (power_ph == PHASE_BREAK) begin
      keys[KEY_POWER_DOWN:KEY_POWER_FREE] = '0;
      power_ph = PHASE_IDLE;
    end

    if (b_ok && b != brake_step && brake_ph == PHASE_IDLE) begin
      if (b == BRAKE_POS_RELEASE) begin
        keys[KEY_BRAKE_FREE] = 1'b1;
      end else if (b == BRAKE_POS_EMRG) begin
        keys[KEY_BRAKE_EMRG] = 1'b1;
      end else if (brake_step > b) begin
        keys[KEY_BRAKE_DOWN] = 1'b1;
      end else begin
        keys[KEY_BRAKE_UP] = 1'b1;
      end
      brake_step = b;
      brake_ph = PHASE_BREAK;
    end else if (brake_ph == PHASE_BREAK) begin
      keys[KEY_BRAKE_EMRG:KEY_BRAKE_FREE] = '0;
      brake_ph = PHASE_IDLE;
    end

    return {brake_step, power_notch, keys};
  endfunction

  task automatic check_key_word(input logic [OUT_DATA_W-1:0] want,
                                input logic [OUT_DATA_W-1:0] got);
    for (int i = 0; i < FLAG_W; i++) begin
      if (got[i] !== want[i]) begin
        $display("%0t key flag %0d: expected %0b actual %0b", $time, i, want[i], got[i]);
        errors++;
      end
    end
    if (got[FLAG_W +: POWER_POS_W] !== want[FLAG_W +: POWER_POS_W]) begin
      $display("%0t power position: expected %0d actual %0d", $time,
               $signed(want[FLAG_W +: POWER_POS_W]), $signed(got[FLAG_W +: POWER_POS_W]));
      errors++;
    end
    if (got[FLAG_W+POWER_POS_W +: BRAKE_POS_W] !== want[FLAG_W+POWER_POS_W +: BRAKE_POS_W]) begin
      $display("%0t brake position: expected %0d actual %0d", $time,
               $signed(want[FLAG_W+POWER_POS_W +: BRAKE_POS_W]),
               $signed(got[FLAG_W+POWER_POS_W +: BRAKE_POS_W]));
      errors++;
    end
  endtask

  // both channels observed with values from just before the edge
  always @(posedge clk) begin
    pin_row_t              row;
    logic [OUT_DATA_W-1:0] predicted;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        row = sent_rows.pop_front();
        predicted = predict_keys(s_tdata);
        key_words_due.push_back(row.typed ? row.want : predicted);
      end
      if (m_tvalid && m_tready) begin
        if (key_words_due.size() == 0) begin
          $display("%0t unexpected transaction: actual %h", $time, m_tdata);
          errors++;
        end else begin
          check_key_word(key_words_due.pop_front(), m_tdata);
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  task automatic send_pins(input logic [31:0] pins, input logic typed,
                           input logic [OUT_DATA_W-1:0] want);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    sent_rows.push_back('{pins, typed, want});
    s_tvalid <= 1'b1;
    s_tdata  <= pins;
    do @(posedge clk); while (!s_tready);
  endtask

  initial begin
    logic [POWER_CODE_W-1:0] pc;
    logic [BRAKE_CODE_W-1:0] bc;
    logic [31:0]             pins;
    power_notch = POWER_POS_INVALID;
    brake_step  = BRAKE_POS_INVALID;
    power_ph    = PHASE_IDLE;
    brake_ph    = PHASE_IDLE;
    keys        = '0;
    pc = '0;
    bc = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_pins(directed_rows[i].pins, directed_rows[i].typed, directed_rows[i].want);
    end

    // random phases: free flowing, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = (ph == 1) ? 62 : (ph == 3) ? 13 : 0;
      sink_stall_pct = (ph == 2) ? 62 : (ph == 3) ? 13 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // levers mostly held still so idle phases and repeats are reached
        if ($urandom_range(0, 99) < 35) pc = POWER_CODE_W'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < 35) bc = BRAKE_CODE_W'($urandom_range(0, 15));
        pins = $urandom;
        pins[POWER_PIN_BASE +: POWER_CODE_W] = pc;
        pins[BRAKE_PIN_BASE +: BRAKE_CODE_W] = bc;
        send_pins(pins, 1'b0, '0);
      end
    end
    s_tvalid <= 1'b0;

    while (key_words_due.size() != 0 || sent_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (key_words_due.size() != 0) begin
      $display("%0t %0d results never arrived", $time, key_words_due.size());
      errors++;
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
